FILE: rtl/ipv4_emrt_pkg.sv
// Package for the IPv4 exact-match rule table.
// Holds the table size, derived widths, the entry layout and the controller state type.
// No dependencies; the request interface, the core and the testbench import it.
`default_nettype none

package ipv4_emrt_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_RULES = 64;
    localparam int ADDR_W    = 32;
    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    // Operation codes of a request.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Status codes of a response.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One stored rule.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              incoming;
        logic              outgoing;
    } entry_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage : ipv4_emrt_pkg

`default_nettype wire

FILE: rtl/ipv4_emrt_req_if.sv
// Request channel of the IPv4 exact-match rule table.
// Carries valid, ready and the request fields; uses ipv4_emrt_pkg for the address width.
`default_nettype none

interface ipv4_emrt_req_if;
    import ipv4_emrt_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] address;
    logic              rule_incoming;
    logic              rule_outgoing;

    modport source (output valid, op, address, rule_incoming, rule_outgoing, input ready);
    modport sink   (input valid, op, address, rule_incoming, rule_outgoing, output ready);

endinterface : ipv4_emrt_req_if

`default_nettype wire

FILE: rtl/ipv4_emrt_rsp_if.sv
// Response channel of the IPv4 exact-match rule table.
// Carries valid, ready and the response fields; no package dependency.
`default_nettype none

interface ipv4_emrt_rsp_if;
    logic valid;
    logic ready;
    logic allow_incoming;
    logic allow_outgoing;
    logic found;
    logic status;

    modport source (output valid, allow_incoming, allow_outgoing, found, status, input ready);
    modport sink   (input valid, allow_incoming, allow_outgoing, found, status, output ready);

endinterface : ipv4_emrt_rsp_if

`default_nettype wire

FILE: rtl/ipv4_exact_match_rule_table_core.sv
// IPv4 exact-match rule table. Rules live in one single-port-read, single-port-write
// synchronous memory of MAX_RULES entries, filled in order from slot 0. A request
// transaction is taken only while the controller is idle; the table is then scanned one
// entry per cycle through the memory read port, stopping at the first matching address.
// The scan compares the entries from slot 0 up to the slot of the match, or all entries on
// a miss; with the one memory read port, a new request is taken only after the previous one
// has been scanned and its response loaded. The result lands in an output register, so the
// next request is accepted while a response still waits.
// Depends on ipv4_emrt_pkg, ipv4_emrt_req_if and ipv4_emrt_rsp_if.
`default_nettype none

module ipv4_exact_match_rule_table_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ipv4_emrt_req_if.sink   req,
    ipv4_emrt_rsp_if.source rsp
);
    import ipv4_emrt_pkg::*;

    // Rule memory and its registered read data.
    entry_t            mem [MAX_RULES];
    entry_t            rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    entry_t            wr_data;

    // Control state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    logic              out_valid_reg, out_valid_next;

    // Payload state.
    logic              op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              inc_reg, inc_next;
    logic              outg_reg, outg_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              hit_inc_reg, hit_inc_next;
    logic              hit_outg_reg, hit_outg_next;
    logic              out_inc_reg, out_inc_next;
    logic              out_outg_reg, out_outg_next;
    logic              out_found_reg, out_found_next;
    logic              out_status_reg, out_status_next;

    logic              req_fire;
    logic              out_free;
    logic              match_now;

    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign match_now = pend_reg && (rd_data_reg.address == addr_reg);

    // Memory: one registered read, one write per cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Next state, memory access and response formation.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        op_next         = op_reg;
        addr_next       = addr_reg;
        inc_next        = inc_reg;
        outg_next       = outg_reg;
        pend_idx_next   = pend_idx_reg;
        slot_next       = slot_reg;
        hit_inc_next    = hit_inc_reg;
        hit_outg_next   = hit_outg_reg;
        out_inc_next    = out_inc_reg;
        out_outg_next   = out_outg_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        rd_idx          = scan_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_idx          = slot_reg;
        wr_data         = '{address: addr_reg, incoming: inc_reg, outgoing: outg_reg};
        req.ready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next    = req.op;
                    addr_next  = req.address;
                    inc_next   = req.rule_incoming;
                    outg_next  = req.rule_outgoing;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle and compare the entry read in the previous cycle.
                rd_en     = (scan_reg < count_reg) && !match_now;
                pend_next = rd_en;
                if (match_now)
                begin
                    hit_next      = 1'b1;
                    slot_next     = pend_idx_reg;
                    hit_inc_next  = rd_data_reg.incoming;
                    hit_outg_next = rd_data_reg.outgoing;
                    state_next    = ST_FINISH;
                end
                else if (rd_en)
                begin
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Once the output register is free, write back the rule on an insert and load the response.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = hit_reg;
                    out_status_next = STATUS_OK;
                    out_inc_next    = 1'b0;
                    out_outg_next   = 1'b0;
                    if (op_reg == OP_INSERT)
                    begin
                        if (hit_reg)
                        begin
                            wr_en  = 1'b1;
                            wr_idx = slot_reg;
                        end
                        else if (count_reg < CNT_W'(MAX_RULES))
                        begin
                            wr_en      = 1'b1;
                            wr_idx     = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            out_status_next = STATUS_FULL;
                        end
                    end
                    else if (hit_reg)
                    begin
                        out_inc_next  = hit_inc_reg;
                        out_outg_next = hit_outg_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        inc_reg        <= inc_next;
        outg_reg       <= outg_next;
        pend_idx_reg   <= pend_idx_next;
        slot_reg       <= slot_next;
        hit_inc_reg    <= hit_inc_next;
        hit_outg_reg   <= hit_outg_next;
        out_inc_reg    <= out_inc_next;
        out_outg_reg   <= out_outg_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
    end

    // Response port.
    assign rsp.valid          = out_valid_reg;
    assign rsp.allow_incoming = out_inc_reg;
    assign rsp.allow_outgoing = out_outg_reg;
    assign rsp.found          = out_found_reg;
    assign rsp.status         = out_status_reg;

    // The entry count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RULES))
        else $error("entry count above table size");

    // The entry count grows by at most one per cycle and never shrinks.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count changed by more than one");

    // The memory is never written while a scan reads it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("memory write during scan");

    // A recorded hit always points at a filled slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && hit_reg) |-> (CNT_W'(slot_reg) < count_reg))
        else $error("hit slot beyond entry count");

endmodule : ipv4_exact_match_rule_table_core

`default_nettype wire

FILE: verif/ipv4_exact_match_rule_table_core_test.sv
// Self-checking testbench for the IPv4 exact-match rule table core.
// Uses ipv4_emrt_pkg and the request and response interfaces from the RTL.
// It runs a table of directed rows, then random traffic checked against an in-bench rule table.

module ipv4_exact_match_rule_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4_emrt_pkg::*;

    localparam int RANDOM_ITEMS  = 830;
    localparam int FILL_ITEMS    = 250;
    localparam int DIRECTED_ROWS = 21;
    localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT       = DIRECTED_ROWS + 30;
    localparam int DRAIN_CYCLES  = MAX_RULES + 8;

    // One request transaction.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic              rule_incoming;
        logic              rule_outgoing;
    } rule_request_t;

    // One response transaction.
    typedef struct packed {
        logic allow_incoming;
        logic allow_outgoing;
        logic found;
        logic status;
    } rule_verdict_t;

    // A directed row; the verdict is only used when typed is set.
    typedef struct packed {
        rule_request_t item;
        logic          typed;
        rule_verdict_t want;
    } directed_row_t;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Lookups on an empty table miss.
        '{'{OP_LOOKUP, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        // New entries at the address extremes.
        '{'{OP_INSERT, 32'h0000_0000, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_LOOKUP, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1, STATUS_OK}},
        '{'{OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, STATUS_OK}},
        // Overwrite of a held address flips both permit bits.
        '{'{OP_INSERT, 32'hC0A8_0001, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_INSERT, 32'hC0A8_0001, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, STATUS_OK}},
        '{'{OP_LOOKUP, 32'hC0A8_0001, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1, STATUS_OK}},
        // Addresses one bit away from a held one miss until they are inserted themselves.
        '{'{OP_LOOKUP, 32'hC0A8_0000, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_LOOKUP, 32'h40A8_0001, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_INSERT, 32'h8000_0000, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_INSERT, 32'h0000_0001, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_LOOKUP, 32'h8000_0000, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_LOOKUP, 32'h0000_0001, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        // Overwrite of slot zero, then a new entry and a near miss.
        '{'{OP_INSERT, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, STATUS_OK}},
        '{'{OP_LOOKUP, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, STATUS_OK}},
        '{'{OP_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_LOOKUP, 32'h7FFF_FFFF, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        '{'{OP_LOOKUP, 32'hFFFF_FFFE, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, STATUS_OK}},
        // Permit bits on a lookup are ignored.
        '{'{OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, STATUS_OK}}
    };

    logic clk = 1'b0;
    logic rst_n;

    ipv4_emrt_req_if req ();
    ipv4_emrt_rsp_if rsp ();

    ipv4_exact_match_rule_table_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Bench copy of the rule table.
    logic [ADDR_W-1:0] rule_addr [MAX_RULES];
    logic              rule_in   [MAX_RULES];
    logic              rule_out  [MAX_RULES];
    int                rule_count = 0;

    rule_verdict_t pending_verdicts [$];
    int            accepted_items = 0;
    int            checked_items  = 0;
    int            errors         = 0;

    // Expectation attached to the transaction on offer.
    logic          offer_typed;
    rule_verdict_t offer_want;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the bench table and returns the verdict it gives.
    function automatic rule_verdict_t apply_rule_request(rule_request_t r);
        rule_verdict_t v;
        int            slot;
        int            i;
        v      = '0;
        v.status = STATUS_OK;
        slot   = -1;
        for (i = 0; i < rule_count; i++)
        begin
            if (slot < 0 && rule_addr[i] == r.address)
                slot = i;
        end
        v.found = (slot >= 0);
        if (r.op == OP_INSERT)
        begin
            if (slot >= 0)
            begin
                rule_in[slot]  = r.rule_incoming;
                rule_out[slot] = r.rule_outgoing;
            end
            else if (rule_count < MAX_RULES)
            begin
                rule_addr[rule_count] = r.address;
                rule_in[rule_count]   = r.rule_incoming;
                rule_out[rule_count]  = r.rule_outgoing;
                rule_count++;
            end
            else
            begin
                v.status = STATUS_FULL;
            end
        end
        else if (slot >= 0)
        begin
            v.allow_incoming = rule_in[slot];
            v.allow_outgoing = rule_out[slot];
        end
        return v;
    endfunction

    // Random request: held addresses, near misses, extremes and fresh ones; mostly held or near after the fill.
    function automatic rule_request_t pick_request(bit filling);
        rule_request_t r;
        int            roll;
        int            held_pct;
        held_pct = filling ? 30 : 55;
        roll     = $urandom_range(0, 99);
        r.op     = ($urandom_range(0, 99) < (filling ? 70 : 50)) ? OP_INSERT : OP_LOOKUP;
        r.rule_incoming = 1'($urandom_range(0, 1));
        r.rule_outgoing = 1'($urandom_range(0, 1));
        if (rule_count > 0 && roll < held_pct)
            r.address = rule_addr[$urandom_range(0, rule_count - 1)];
        else if (rule_count > 0 && roll < held_pct + 10)
            r.address = rule_addr[$urandom_range(0, rule_count - 1)]
                        ^ (32'h1 << $urandom_range(0, ADDR_W - 1));
        else if (roll < held_pct + 15)
        begin
            case ($urandom_range(0, 3))
                0:       r.address = 32'h0000_0000;
                1:       r.address = 32'hFFFF_FFFF;
                2:       r.address = 32'h8000_0000;
                default: r.address = 32'h7FFF_FFFF;
            endcase
        end
        else
            r.address = $urandom();
        return r;
    endfunction

    // No idling in the closing stretch, nor in the last 100 of every 300 transactions.
    function automatic bit idling_off();
        return (accepted_items >= TOTAL_ITEMS - 100) || (accepted_items % 300 >= 200);
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Offers one request transaction from a falling edge and returns at the falling
    // edge after it is accepted.
    task automatic send_request(rule_request_t r, logic typed, rule_verdict_t want);
        int gap;
        if (!idling_off() && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.op            <= r.op;
        req.address       <= r.address;
        req.rule_incoming <= r.rule_incoming;
        req.rule_outgoing <= r.rule_outgoing;
        offer_typed       <= typed;
        offer_want        <= want;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    // Monitor: checks responses and records the verdict of each accepted request.
    always @(posedge clk)
    begin
        rule_verdict_t v;
        rule_verdict_t w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_verdicts.size() == 0)
                flag_error("response transaction with no request outstanding");
            else
            begin
                w = pending_verdicts.pop_front();
                if (rsp.allow_incoming !== w.allow_incoming)
                    flag_error($sformatf("item %0d allow_incoming %b, expected %b",
                                         checked_items, rsp.allow_incoming, w.allow_incoming));
                if (rsp.allow_outgoing !== w.allow_outgoing)
                    flag_error($sformatf("item %0d allow_outgoing %b, expected %b",
                                         checked_items, rsp.allow_outgoing, w.allow_outgoing));
                if (rsp.found !== w.found)
                    flag_error($sformatf("item %0d found %b, expected %b",
                                         checked_items, rsp.found, w.found));
                if (rsp.status !== w.status)
                    flag_error($sformatf("item %0d status %b, expected %b",
                                         checked_items, rsp.status, w.status));
            end
            checked_items++;
        end
        if (rst_n && req.valid && req.ready)
        begin
            v = apply_rule_request('{req.op, req.address, req.rule_incoming,
                                     req.rule_outgoing});
            pending_verdicts.push_back(offer_typed ? offer_want : v);
            accepted_items++;
        end
    end

    // Response side: short random stalls and one long hold-off early in the random part.
    initial
    begin
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        logic take;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        rsp.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && accepted_items == HOLD_AT)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                take = 1'b0;
            end
            else if (!idling_off() && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                take = 1'b0;
            end
            else
                take = 1'b1;
            rsp.ready <= take;
        end
    end

    // Request side: reset, directed table, pause until drained, then random traffic.
    initial
    begin
        int row;
        int n;
        rst_n             = 1'b0;
        req.valid         = 1'b0;
        req.op            = OP_INSERT;
        req.address       = '0;
        req.rule_incoming = 1'b0;
        req.rule_outgoing = 1'b0;
        offer_typed       = 1'b0;
        offer_want        = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
            send_request(DIRECTED[row].item, DIRECTED[row].typed, DIRECTED[row].want);

        // Let every outstanding response come back before the random part.
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_verdicts.size() != 0);

        for (n = 0; n < RANDOM_ITEMS; n++)
            send_request(pick_request(n < FILL_ITEMS), 1'b0, '0);
        req.valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("ipv4_exact_match_rule_table_core_test OK");
        else
            $display("ipv4_exact_match_rule_table_core_test NOT OK");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #5_000_000;
        $display("timeout with %0d responses outstanding", pending_verdicts.size());
        $display("ipv4_exact_match_rule_table_core_test NOT OK");
        $finish;
    end

endmodule : ipv4_exact_match_rule_table_core_test
